// ===== hw/rtl/dpid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpid_pkg - shared types and constants of the dual PID velocity controller
// Widths, microcode word layout, control/status bundles and the control ROM.
// ----------------------------------------------------------------------------
package dpid_pkg;

    localparam int DATA_W  = 32;  // Q16.16 errors, gains, outputs
    localparam int DT_W    = 16;  // Q0.16 time step
    localparam int LIM_W   = 31;  // clamp magnitude
    localparam int INTEG_W = 48;  // Q32.16 integral
    localparam int QUO_W   = 48;  // (|diff| << 16) / dt
    localparam int VMAG_W  = 48;  // largest multiplier operand magnitude
    localparam int HI_W    = 48;  // gain times upper operand bits
    localparam int PROD_W  = 64;
    localparam int TERM_W  = 61;  // term magnitude, up to 2^60
    localparam int ACC_W   = 63;  // integral plus one term
    localparam int SUM_W   = 64;  // P + I + D
    localparam int PC_W    = 6;
    localparam int CFG_AW  = 5;
    localparam int PDATA_W = 32;

    localparam logic [DATA_W-1:0]  DATA_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0]  DATA_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic [TERM_W-1:0]  TERM_SAT  = {1'b1, {(TERM_W-1){1'b0}}};
    localparam logic [LIM_W-1:0]   LIM_RESET = LIM_W'(65536);

    localparam logic LANE_LIN = 1'b0;
    localparam logic LANE_ANG = 1'b1;

    typedef enum logic [2:0] {
        REG_LIN_P,
        REG_LIN_I,
        REG_LIN_D,
        REG_ANG_P,
        REG_ANG_I,
        REG_ANG_D,
        REG_LIN_LIM,
        REG_ANG_LIM
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIVGO,   // record diffs, start divider, clear sums
        OP_LD,      // load multiplier operands
        OP_MLO,     // gain times low operand word
        OP_MHI,     // gain times high operand bits
        OP_TERM,    // scale and saturate the product
        OP_IADD,    // add term to integral, saturate
        OP_SADD,    // add term to loop sum
        OP_CLAMP    // clamp both sums into the output register
    } op_t;

    typedef enum logic [1:0] {
        SRC_INC,    // time step times error
        SRC_P,
        SRC_I,
        SRC_D
    } src_t;

    typedef enum logic [1:0] {
        JC_NEXT,
        JC_SKIPD,   // jump to target when no D term is formed
        JC_DIVWAIT, // hold while the divider runs
        JC_END      // hold while the output is full, then finish
    } jc_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        op_t             op;
        logic            lane;
        src_t            src;
        jc_t             jc;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic lane;
        src_t src;
        logic accept;
    } dpid_ctrl_t;

    typedef struct packed {
        logic skip_d;
        logic div_busy;
        logic out_busy;
    } dpid_stat_t;

    typedef struct packed {
        logic [1:0][DATA_W-1:0] p_gain;
        logic [1:0][DATA_W-1:0] i_gain;
        logic [1:0][DATA_W-1:0] d_gain;
        logic [1:0][LIM_W-1:0]  limit;
    } dpid_cfg_t;

    localparam logic [PC_W-1:0] PC_CLAMP = 6'd43;

    function automatic ucode_t uc(op_t op, logic lane, src_t src, jc_t jc,
                                  logic [PC_W-1:0] target);
        ucode_t w;
        w.op     = op;
        w.lane   = lane;
        w.src    = src;
        w.jc     = jc;
        w.target = target;
        return w;
    endfunction

    // Control program, one word per step.
    function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
        ucode_t w;
        ucode_t mlo;
        ucode_t mhi;
        ucode_t trm;
        mlo = uc(OP_MLO, LANE_LIN, SRC_INC, JC_NEXT, '0);
        mhi = uc(OP_MHI, LANE_LIN, SRC_INC, JC_NEXT, '0);
        trm = uc(OP_TERM, LANE_LIN, SRC_INC, JC_NEXT, '0);
        w   = uc(OP_NOP, LANE_LIN, SRC_INC, JC_END, '0);
        case (pc)
            6'd0:  w = uc(OP_DIVGO, LANE_LIN, SRC_INC, JC_NEXT, '0);
            // integrals
            6'd1:  w = uc(OP_LD, LANE_LIN, SRC_INC, JC_NEXT, '0);
            6'd2:  w = mlo;
            6'd3:  w = mhi;
            6'd4:  w = trm;
            6'd5:  w = uc(OP_IADD, LANE_LIN, SRC_INC, JC_NEXT, '0);
            6'd6:  w = uc(OP_LD, LANE_ANG, SRC_INC, JC_NEXT, '0);
            6'd7:  w = mlo;
            6'd8:  w = mhi;
            6'd9:  w = trm;
            6'd10: w = uc(OP_IADD, LANE_ANG, SRC_INC, JC_NEXT, '0);
            // P and I terms
            6'd11: w = uc(OP_LD, LANE_LIN, SRC_P, JC_NEXT, '0);
            6'd12: w = mlo;
            6'd13: w = mhi;
            6'd14: w = trm;
            6'd15: w = uc(OP_SADD, LANE_LIN, SRC_P, JC_NEXT, '0);
            6'd16: w = uc(OP_LD, LANE_LIN, SRC_I, JC_NEXT, '0);
            6'd17: w = mlo;
            6'd18: w = mhi;
            6'd19: w = trm;
            6'd20: w = uc(OP_SADD, LANE_LIN, SRC_I, JC_NEXT, '0);
            6'd21: w = uc(OP_LD, LANE_ANG, SRC_P, JC_NEXT, '0);
            6'd22: w = mlo;
            6'd23: w = mhi;
            6'd24: w = trm;
            6'd25: w = uc(OP_SADD, LANE_ANG, SRC_P, JC_NEXT, '0);
            6'd26: w = uc(OP_LD, LANE_ANG, SRC_I, JC_NEXT, '0);
            6'd27: w = mlo;
            6'd28: w = mhi;
            6'd29: w = trm;
            6'd30: w = uc(OP_SADD, LANE_ANG, SRC_I, JC_NEXT, '0);
            // D terms
            6'd31: w = uc(OP_NOP, LANE_LIN, SRC_INC, JC_SKIPD, PC_CLAMP);
            6'd32: w = uc(OP_NOP, LANE_LIN, SRC_INC, JC_DIVWAIT, '0);
            6'd33: w = uc(OP_LD, LANE_LIN, SRC_D, JC_NEXT, '0);
            6'd34: w = mlo;
            6'd35: w = mhi;
            6'd36: w = trm;
            6'd37: w = uc(OP_SADD, LANE_LIN, SRC_D, JC_NEXT, '0);
            6'd38: w = uc(OP_LD, LANE_ANG, SRC_D, JC_NEXT, '0);
            6'd39: w = mlo;
            6'd40: w = mhi;
            6'd41: w = trm;
            6'd42: w = uc(OP_SADD, LANE_ANG, SRC_D, JC_NEXT, '0);
            6'd43: w = uc(OP_CLAMP, LANE_LIN, SRC_INC, JC_END, '0);
            default: w = uc(OP_NOP, LANE_LIN, SRC_INC, JC_END, '0);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dpid_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpid_div - two-lane serial divider
// Restoring division, one quotient bit per lane per cycle, shared divisor.
// ----------------------------------------------------------------------------
module dpid_div
    import dpid_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0][DATA_W-1:0] num,
    input  logic [DT_W-1:0]        den,
    output logic [1:0][QUO_W-1:0]  quo,
    output logic                   busy
);

    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic [1:0][QUO_W-1:0] shq_reg;
    logic [1:0][QUO_W-1:0] shq_next;
    logic [1:0][DT_W-1:0]  rem_reg;
    logic [1:0][DT_W-1:0]  rem_next;
    logic [1:0][DT_W:0]    trial;
    logic [1:0][DT_W:0]    trial_sub;
    logic [1:0]            trial_ge;
    logic [DT_W-1:0]       den_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            trial[l]     = {rem_reg[l], shq_reg[l][QUO_W-1]};
            trial_sub[l] = trial[l] - {1'b0, den_reg};
            trial_ge[l]  = trial[l] >= {1'b0, den_reg};
            rem_next[l]  = trial_ge[l] ? trial_sub[l][DT_W-1:0] : trial[l][DT_W-1:0];
            shq_next[l]  = {shq_reg[l][QUO_W-2:0], trial_ge[l]};
        end
    end

    // a start while busy drops the running division and begins anew
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // numerator is |diff| << 16
            for (int l = 0; l < 2; l++)
            begin
                shq_reg[l] <= {num[l], {(QUO_W-DATA_W){1'b0}}};
                rem_reg[l] <= '0;
            end
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            shq_reg <= shq_next;
            rem_reg <= rem_next;
        end
    end

    assign quo  = shq_reg;
    assign busy = busy_reg;

    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == '0)
        else $error("divider did not begin a fresh division on start");

endmodule
`default_nettype wire

// ===== hw/rtl/dpid_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpid_cfg - configuration register file
// APB-style write/read of the six gains and two speed limits.
// ----------------------------------------------------------------------------
module dpid_cfg
    import dpid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output dpid_cfg_t          cfg
);

    logic [1:0][DATA_W-1:0] p_reg;
    logic [1:0][DATA_W-1:0] i_reg;
    logic [1:0][DATA_W-1:0] d_reg;
    logic [1:0][LIM_W-1:0]  lim_reg;
    reg_idx_t               idx;
    logic                   wr;

    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg   <= '0;
            i_reg   <= '0;
            d_reg   <= '0;
            lim_reg <= {LIM_RESET, LIM_RESET};
        end
        else if (wr)
        begin
            case (idx)
                REG_LIN_P:   p_reg[LANE_LIN]   <= pwdata;
                REG_LIN_I:   i_reg[LANE_LIN]   <= pwdata;
                REG_LIN_D:   d_reg[LANE_LIN]   <= pwdata;
                REG_ANG_P:   p_reg[LANE_ANG]   <= pwdata;
                REG_ANG_I:   i_reg[LANE_ANG]   <= pwdata;
                REG_ANG_D:   d_reg[LANE_ANG]   <= pwdata;
                REG_LIN_LIM: lim_reg[LANE_LIN] <= pwdata[LIM_W-1:0];
                REG_ANG_LIM: lim_reg[LANE_ANG] <= pwdata[LIM_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LIN_P:   prdata = p_reg[LANE_LIN];
            REG_LIN_I:   prdata = i_reg[LANE_LIN];
            REG_LIN_D:   prdata = d_reg[LANE_LIN];
            REG_ANG_P:   prdata = p_reg[LANE_ANG];
            REG_ANG_I:   prdata = i_reg[LANE_ANG];
            REG_ANG_D:   prdata = d_reg[LANE_ANG];
            REG_LIN_LIM: prdata = {1'b0, lim_reg[LANE_LIN]};
            REG_ANG_LIM: prdata = {1'b0, lim_reg[LANE_ANG]};
            default:     prdata = '0;
        endcase
    end

    assign cfg.p_gain = p_reg;
    assign cfg.i_gain = i_reg;
    assign cfg.d_gain = d_reg;
    assign cfg.limit  = lim_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/dpid_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpid_seq - microcode sequencer
// Step counter over the control ROM with conditional jumps and holds.
// ----------------------------------------------------------------------------
module dpid_seq
    import dpid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dpid_stat_t stat,
    output logic       in_stall,
    output dpid_ctrl_t ctrl
);

    seq_state_t      state_reg;
    seq_state_t      state_next;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          word;

    assign word = ucode_rom(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        in_stall    = 1'b1;
        ctrl.op     = OP_NOP;
        ctrl.lane   = word.lane;
        ctrl.src    = word.src;
        ctrl.accept = 1'b0;
        case (state_reg)
            SEQ_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = SEQ_RUN;
                    pc_next     = '0;
                end
            end
            SEQ_RUN:
            begin
                ctrl.op = word.op;
                case (word.jc)
                    JC_NEXT:    pc_next = pc_reg + 1'b1;
                    JC_SKIPD:   pc_next = stat.skip_d ? word.target : pc_reg + 1'b1;
                    JC_DIVWAIT:
                    begin
                        if (!stat.div_busy)
                        begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    JC_END:
                    begin
                        // hold the step until the output register frees up
                        if (stat.out_busy)
                        begin
                            ctrl.op = OP_NOP;
                        end
                        else
                        begin
                            state_next = SEQ_IDLE;
                            pc_next    = '0;
                        end
                    end
                    default:
                    begin
                        state_next = SEQ_IDLE;
                        pc_next    = '0;
                    end
                endcase
            end
            default:
            begin
                state_next = SEQ_IDLE;
                pc_next    = '0;
            end
        endcase
    end

    a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SEQ_IDLE |-> pc_reg == '0)
        else $error("sequencer idle away from the first step");

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.accept |=> state_reg == SEQ_RUN && pc_reg == '0)
        else $error("accepted beat did not start the program");

endmodule
`default_nettype wire

// ===== hw/rtl/dpid_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpid_dp - controller datapath
// Loop state, shared multiplier with term scaling, sums, clamp and output.
// ----------------------------------------------------------------------------
module dpid_dp
    import dpid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dpid_ctrl_t               ctrl,
    input  dpid_cfg_t                cfg,
    input  logic signed [DATA_W-1:0] dist_err,
    input  logic signed [DATA_W-1:0] angle_err,
    input  logic [DT_W-1:0]          time_step,
    input  logic                     out_stall,
    output dpid_stat_t               stat,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] lin_vel,
    output logic signed [DATA_W-1:0] ang_vel
);

    // loop state and item operands
    logic [1:0][DATA_W-1:0]  err_reg;
    logic [1:0][DATA_W-1:0]  prev_reg;
    logic [1:0][INTEG_W-1:0] integ_reg;
    logic [1:0]              dsign_reg;
    logic [DT_W-1:0]         dt_reg;
    logic                    first_reg;

    // multiply and accumulate
    logic [DATA_W-1:0]       ga_reg;
    logic [VMAG_W-1:0]       va_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       lo_reg;
    logic [HI_W-1:0]         hi_reg;
    logic [TERM_W-1:0]       term_reg;
    logic                    tneg_reg;
    logic [1:0][SUM_W-1:0]   sum_reg;

    logic [1:0][DATA_W-1:0]  out_reg;
    logic                    out_valid_reg;

    logic [DATA_W-1:0]       ang_neg;
    logic [1:0][DATA_W:0]    diff_up;
    logic [1:0][DATA_W:0]    diff_dn;
    logic [1:0]              diff_lt;
    logic [1:0][DATA_W-1:0]  diff_mag;
    logic [1:0][QUO_W-1:0]   quo;
    logic                    div_busy;

    logic [DATA_W-1:0]       gsel;
    logic [VMAG_W-1:0]       vsel;
    logic [DATA_W-1:0]       gmag;
    logic [VMAG_W-1:0]       vmag;
    logic                    vneg;

    logic [DATA_W-1:0]       mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic [TERM_W-1:0]       term_sum;
    logic [TERM_W-1:0]       term_mag;

    logic [ACC_W-1:0]        integ_ext;
    logic [ACC_W-1:0]        term_ext;
    logic [ACC_W-1:0]        integ_acc;
    logic [INTEG_W-1:0]      integ_sat;
    logic [SUM_W-1:0]        sum_term;
    logic [SUM_W-1:0]        sum_new;

    logic [1:0][SUM_W-1:0]   lim_ext;
    logic [1:0][SUM_W-1:0]   nlim_ext;
    logic [1:0][DATA_W-1:0]  clamp;

    // negate the angle error, saturating the most negative code
    assign ang_neg = (angle_err == DATA_MIN) ? DATA_MAX : ({DATA_W{1'b0}} - angle_err);

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            diff_up[l]  = {err_reg[l][DATA_W-1], err_reg[l]}
                        - {prev_reg[l][DATA_W-1], prev_reg[l]};
            diff_dn[l]  = {prev_reg[l][DATA_W-1], prev_reg[l]}
                        - {err_reg[l][DATA_W-1], err_reg[l]};
            diff_lt[l]  = $signed(err_reg[l]) < $signed(prev_reg[l]);
            diff_mag[l] = diff_lt[l] ? diff_dn[l][DATA_W-1:0] : diff_up[l][DATA_W-1:0];
        end
    end

    dpid_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.op == OP_DIVGO),
        .num   (diff_mag),
        .den   (dt_reg),
        .quo   (quo),
        .busy  (div_busy)
    );

    // operand selection for a term
    always_comb
    begin
        case (ctrl.src)
            SRC_INC: gsel = {{(DATA_W-DT_W){1'b0}}, dt_reg};
            SRC_P:   gsel = cfg.p_gain[ctrl.lane];
            SRC_I:   gsel = cfg.i_gain[ctrl.lane];
            SRC_D:   gsel = cfg.d_gain[ctrl.lane];
            default: gsel = '0;
        endcase
        if (ctrl.src == SRC_I)
        begin
            vsel = integ_reg[ctrl.lane];
        end
        else
        begin
            vsel = {{(VMAG_W-DATA_W){err_reg[ctrl.lane][DATA_W-1]}}, err_reg[ctrl.lane]};
        end
        gmag = gsel[DATA_W-1] ? ({DATA_W{1'b0}} - gsel) : gsel;
        if (ctrl.src == SRC_D)
        begin
            vmag = quo[ctrl.lane];
            vneg = dsign_reg[ctrl.lane];
        end
        else
        begin
            vmag = vsel[VMAG_W-1] ? ({VMAG_W{1'b0}} - vsel) : vsel;
            vneg = vsel[VMAG_W-1];
        end
    end

    // one shared 32x32 multiplier for both halves of the operand
    assign mul_b = (ctrl.op == OP_MHI)
                 ? {{(DATA_W-(VMAG_W-DATA_W)){1'b0}}, va_reg[VMAG_W-1:DATA_W]}
                 : va_reg[DATA_W-1:0];
    assign mul_p = ga_reg * mul_b;

    // product >> 16, saturated to 2^60
    assign term_sum = {1'b0, hi_reg[TERM_W-18:0], 16'b0}
                    + {{(TERM_W-(PROD_W-16)){1'b0}}, lo_reg[PROD_W-1:16]};
    assign term_mag = ((|hi_reg[HI_W-1:TERM_W-17]) || (term_sum > TERM_SAT))
                    ? TERM_SAT : term_sum;

    // integral update with saturation
    assign integ_ext = {{(ACC_W-INTEG_W){integ_reg[ctrl.lane][INTEG_W-1]}},
                        integ_reg[ctrl.lane]};
    assign term_ext  = {{(ACC_W-TERM_W){1'b0}}, term_reg};
    assign integ_acc = tneg_reg ? (integ_ext - term_ext) : (integ_ext + term_ext);
    assign integ_sat = ((&integ_acc[ACC_W-1:INTEG_W-1]) || (~|integ_acc[ACC_W-1:INTEG_W-1]))
                     ? integ_acc[INTEG_W-1:0]
                     : (integ_acc[ACC_W-1] ? INTEG_MIN : INTEG_MAX);

    assign sum_term = {{(SUM_W-TERM_W){1'b0}}, term_reg};
    assign sum_new  = tneg_reg ? (sum_reg[ctrl.lane] - sum_term)
                               : (sum_reg[ctrl.lane] + sum_term);

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            lim_ext[l]  = {{(SUM_W-LIM_W){1'b0}}, cfg.limit[l]};
            nlim_ext[l] = {SUM_W{1'b0}} - lim_ext[l];
            if ($signed(sum_reg[l]) > $signed(lim_ext[l]))
            begin
                clamp[l] = lim_ext[l][DATA_W-1:0];
            end
            else if ($signed(sum_reg[l]) < $signed(nlim_ext[l]))
            begin
                clamp[l] = nlim_ext[l][DATA_W-1:0];
            end
            else
            begin
                clamp[l] = sum_reg[l][DATA_W-1:0];
            end
        end
    end

    // loop state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            integ_reg     <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (ctrl.op)
                OP_DIVGO: prev_reg <= err_reg;
                OP_IADD:  integ_reg[ctrl.lane] <= integ_sat;
                OP_CLAMP: first_reg <= 1'b0;
                default:  ;
            endcase
            if (ctrl.op == OP_CLAMP)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            err_reg[LANE_LIN] <= dist_err;
            err_reg[LANE_ANG] <= ang_neg;
            dt_reg            <= time_step;
        end
        case (ctrl.op)
            OP_DIVGO:
            begin
                dsign_reg <= diff_lt;
                sum_reg   <= '0;
            end
            OP_LD:
            begin
                ga_reg  <= gmag;
                va_reg  <= vmag;
                neg_reg <= gsel[DATA_W-1] ^ vneg;
            end
            OP_MLO:   lo_reg <= mul_p;
            OP_MHI:   hi_reg <= mul_p[HI_W-1:0];
            OP_TERM:
            begin
                term_reg <= term_mag;
                tneg_reg <= neg_reg;
            end
            OP_SADD:  sum_reg[ctrl.lane] <= sum_new;
            OP_CLAMP: out_reg <= clamp;
            default:  ;
        endcase
    end

    assign stat.skip_d   = first_reg || (dt_reg == '0);
    assign stat.div_busy = div_busy;
    assign stat.out_busy = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign lin_vel   = out_reg[LANE_LIN];
    assign ang_vel   = out_reg[LANE_ANG];

    a_quotient_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_LD && ctrl.src == SRC_D) |-> !div_busy)
        else $error("derivative operand loaded before the divider finished");

    a_clamp_publishes: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_CLAMP |=> out_valid_reg && !first_reg)
        else $error("clamp step did not publish a result");

endmodule
`default_nettype wire

// ===== hw/rtl/dual_pid_velocity_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_pid_velocity_controller - two fixed-point PID loops with output clamp
// Distance and angle loops sharing one multiplier and one two-lane divider,
// driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake            | beat
//   ---------+-----------+----------------------+----------------------------
//   in       | in        | in_valid / in_stall  | dist_err, angle_err, time_step
//   out      | out       | out_valid / out_stall| lin_vel, ang_vel
//   config   | in        | psel/penable/pready  | paddr, pwdata, prdata
//
// An item waits for the restoring divider before its D terms are formed;
// without D terms the program goes from the P and I terms to the clamp.
// One item is in flight at a time; in_stall is high until its result is
// loaded into the output register. A stalled output holds the final step.
// Reset is asynchronous, active low: integrals and previous errors clear,
// gains clear and both speed limits return to 1.0.
// ----------------------------------------------------------------------------
module dual_pid_velocity_controller
    import dpid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] dist_err,
    input  logic signed [DATA_W-1:0] angle_err,
    input  logic [DT_W-1:0]          time_step,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] lin_vel,
    output logic signed [DATA_W-1:0] ang_vel,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_AW-1:0]        paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    dpid_cfg_t  cfg;
    dpid_ctrl_t ctrl;
    dpid_stat_t stat;

    dpid_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpid_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    dpid_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg       (cfg),
        .dist_err  (dist_err),
        .angle_err (angle_err),
        .time_step (time_step),
        .out_stall (out_stall),
        .stat      (stat),
        .out_valid (out_valid),
        .lin_vel   (lin_vel),
        .ang_vel   (ang_vel)
    );

endmodule
`default_nettype wire

// ===== tb/dual_pid_velocity_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pid_velocity_checker - velocity command predictor and scoreboard
// Watches the command, result and register ports of the dual PID velocity
// controller, predicts the velocity pair of every accepted command from the
// programmed gains and its own loop state, and compares the results in order.
// ----------------------------------------------------------------------------
module dual_pid_velocity_checker
    import dpid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [DATA_W-1:0] dist_err,
    input  logic signed [DATA_W-1:0] angle_err,
    input  logic [DT_W-1:0]          time_step,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [DATA_W-1:0] lin_vel,
    input  logic signed [DATA_W-1:0] ang_vel,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [CFG_AW-1:0]        paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output int                       n_fail,
    output int                       n_pending,
    output int                       n_checked,
    output int                       n_clamped,
    output int                       n_deriv
);

    localparam longint       INTEG_HI   = 64'sd140737488355327;
    localparam longint       INTEG_LO   = -64'sd140737488355328;
    localparam longint       ERR_HI     = 64'sd2147483647;
    localparam logic [127:0] TERM_CAP   = 128'd1 << 60;
    localparam int           REPORT_MAX = 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] lin;
        logic signed [DATA_W-1:0] ang;
    } vel_pair_t;

    logic signed [DATA_W-1:0] p_gain [2];
    logic signed [DATA_W-1:0] i_gain [2];
    logic signed [DATA_W-1:0] d_gain [2];
    logic [LIM_W-1:0]         speed_lim [2];
    longint                   integ_acc [2];
    longint                   prev_err [2];
    logic                     first_cmd;
    vel_pair_t                vel_q [$];

    int fails     = 0;
    int checked   = 0;
    int clamped   = 0;
    int deriv_cnt = 0;

    // trunc(g * v / 2^16) on the magnitudes, capped at 2^60
    function automatic longint scaled_product(longint g, longint v);
        logic [127:0] ga;
        logic [127:0] va;
        logic [127:0] p;
        longint       r;
        ga = (g < 0) ? -g : g;
        va = (v < 0) ? -v : v;
        p  = (ga * va) >> 16;
        if (p > TERM_CAP)
            p = TERM_CAP;
        r = longint'(p[63:0]);
        return ((g < 0) != (v < 0)) ? -r : r;
    endfunction

    // Advance one loop by one command and return its clamped output.
    function automatic longint loop_update(logic lane, longint err, longint dt);
        longint      acc;
        longint      diff;
        longint      rate;
        longint      d_term;
        longint      total;
        longint      lim;
        logic [63:0] diff_mag;
        acc = integ_acc[lane] + scaled_product(dt, err);
        if (acc > INTEG_HI)
            acc = INTEG_HI;
        if (acc < INTEG_LO)
            acc = INTEG_LO;
        integ_acc[lane] = acc;

        d_term = 0;
        if (!first_cmd && dt != 0)
        begin
            diff     = err - prev_err[lane];
            diff_mag = (diff < 0) ? -diff : diff;
            rate     = longint'((diff_mag << 16) / $unsigned(dt));
            if (diff < 0)
                rate = -rate;
            d_term = scaled_product(d_gain[lane], rate);
        end
        prev_err[lane] = err;

        total = scaled_product(p_gain[lane], err) + scaled_product(i_gain[lane], acc)
              + d_term;
        lim = longint'(speed_lim[lane]);
        if (total > lim || total < -lim)
            clamped++;
        if (total > lim)
            total = lim;
        else if (total < -lim)
            total = -lim;
        return total;
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            fails++;
            if (fails <= REPORT_MAX)
                $display("%0t: %s mismatch on result %0d: expected %0d (0x%08h), got %0d (0x%08h)",
                         $time, name, checked, $signed(want), want, $signed(got), got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        vel_pair_t want;
        longint    ang_neg;
        if (!rst_n)
        begin
            p_gain    = '{default: '0};
            i_gain    = '{default: '0};
            d_gain    = '{default: '0};
            speed_lim = '{default: LIM_RESET};
            integ_acc = '{default: 0};
            prev_err  = '{default: 0};
            first_cmd = 1'b1;
            vel_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[CFG_AW-1:2]))
                    REG_LIN_P:   p_gain[LANE_LIN]    = pwdata;
                    REG_LIN_I:   i_gain[LANE_LIN]    = pwdata;
                    REG_LIN_D:   d_gain[LANE_LIN]    = pwdata;
                    REG_ANG_P:   p_gain[LANE_ANG]    = pwdata;
                    REG_ANG_I:   i_gain[LANE_ANG]    = pwdata;
                    REG_ANG_D:   d_gain[LANE_ANG]    = pwdata;
                    REG_LIN_LIM: speed_lim[LANE_LIN] = pwdata[LIM_W-1:0];
                    REG_ANG_LIM: speed_lim[LANE_ANG] = pwdata[LIM_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                // negate the angle error, saturating the most negative value
                ang_neg = -longint'(angle_err);
                if (ang_neg > ERR_HI)
                    ang_neg = ERR_HI;
                if (!first_cmd && time_step != 0)
                    deriv_cnt++;
                want.lin  = DATA_W'(loop_update(LANE_LIN, dist_err, time_step));
                want.ang  = DATA_W'(loop_update(LANE_ANG, ang_neg, time_step));
                first_cmd = 1'b0;
                vel_q.push_back(want);
            end

            if (out_valid && !out_stall)
            begin
                if (vel_q.size() == 0)
                begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("%0t: result beat with no command pending: lin %0d ang %0d",
                                 $time, lin_vel, ang_vel);
                end
                else
                begin
                    want = vel_q.pop_front();
                    check_field("lin_vel", want.lin, lin_vel);
                    check_field("ang_vel", want.ang, ang_vel);
                    checked++;
                end
            end
        end
        n_fail    <= fails;
        n_pending <= vel_q.size();
        n_checked <= checked;
        n_clamped <= clamped;
        n_deriv   <= deriv_cnt;
    end

endmodule

// ===== tb/dual_pid_velocity_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pid_velocity_controller_tb - top of the velocity controller bench
// Programs gains and speed limits over the register port, drives directed
// and random error/step commands with random gaps and result back-pressure,
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module dual_pid_velocity_controller_tb;
    import dpid_pkg::*;

    localparam int                N_RANDOM       = 1100;
    localparam int                QUIET_FROM     = 1000;
    localparam int                RECONFIG_EVERY = 180;
    localparam int                WATCHDOG_LIMIT = 2000;
    localparam int                DRAIN_CYCLES   = 80;
    localparam logic [DATA_W-1:0] ONE            = 32'h0001_0000;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] dist_err  = '0;
    logic signed [DATA_W-1:0] angle_err = '0;
    logic [DT_W-1:0]          time_step = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] lin_vel;
    logic signed [DATA_W-1:0] ang_vel;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [CFG_AW-1:0]        paddr   = '0;
    logic [PDATA_W-1:0]       pwdata  = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    logic idle_on     = 1'b1;
    int   idle_cycles = 0;
    int   cmds_sent   = 0;
    int   settings    = 0;
    int   n_fail;
    int   n_pending;
    int   n_checked;
    int   n_clamped;
    int   n_deriv;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dual_pid_velocity_controller u_top (.*);

    dual_pid_velocity_checker u_checker (.*);

    // result back-pressure in random bursts
    always @(posedge clk)
    begin : stall_gen
        int stall_left;
        if (!idle_on)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 15) == 0)
                stall_left = $urandom_range(1, 13);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
                     idle_cycles, n_pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one command beat and hold it until accepted.
    task automatic send_cmd(logic signed [DATA_W-1:0] d, logic signed [DATA_W-1:0] a,
                            logic [DT_W-1:0] t);
        in_valid  <= 1'b1;
        dist_err  <= d;
        angle_err <= a;
        time_step <= t;
        do
            @(posedge clk);
        while (in_stall);
        cmds_sent++;
    endtask

    task automatic hold_off(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    task automatic program_regs(logic [31:0] lp, logic [31:0] li, logic [31:0] ld,
                                logic [31:0] ap, logic [31:0] ai, logic [31:0] ad,
                                logic [31:0] llim, logic [31:0] alim);
        wait_drained();
        reg_write(REG_LIN_P, lp);
        reg_write(REG_LIN_I, li);
        reg_write(REG_LIN_D, ld);
        reg_write(REG_ANG_P, ap);
        reg_write(REG_ANG_I, ai);
        reg_write(REG_ANG_D, ad);
        reg_write(REG_LIN_LIM, llim);
        reg_write(REG_ANG_LIM, alim);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings++;
    endtask

    function automatic logic [DATA_W-1:0] rand_err();
        int                sel;
        logic [DATA_W-1:0] m;
        sel = $urandom_range(0, 5);
        case (sel)
            0: m = $urandom;
            1:
                case ($urandom_range(0, 4))
                    0: m = DATA_MAX;
                    1: m = DATA_MIN;
                    2: m = '0;
                    3: m = '1;
                    default: m = ONE;
                endcase
            2, 3: m = $urandom_range(0, 32'h0003_FFFF);
            default: m = $urandom_range(0, 32'h00FF_FFFF);
        endcase
        if (sel >= 2 && $urandom_range(0, 1) == 1)
            m = -m;
        return m;
    endfunction

    function automatic logic [DT_W-1:0] rand_step();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return DT_W'($urandom_range(1, 16));
            2: return '1;
            3: return DT_W'($urandom_range(1, 255));
            default: return DT_W'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        logic [31:0] g;
        case ($urandom_range(0, 5))
            0: g = $urandom;
            1:
                case ($urandom_range(0, 2))
                    0: g = DATA_MAX;
                    1: g = DATA_MIN;
                    default: g = '0;
                endcase
            default:
            begin
                g = $urandom_range(0, 32'h0004_0000);
                if ($urandom_range(0, 1) == 1)
                    g = -g;
            end
        endcase
        return g;
    endfunction

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(32'h100, 32'h8_0000);
        endcase
    endfunction

    initial
    begin
        bit bursty;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // moderate gains, widest limits; angle limit written with bit 31 set
        program_regs(ONE, ONE >> 1, ONE >> 2, -ONE, ONE >> 1, ONE >> 3,
                     DATA_MAX, 32'hFFFF_FFFF);
        send_cmd(ONE, ONE >> 1, 16'h8000);      // first command: no D term
        send_cmd(2 * ONE, -(ONE >> 1), 16'h0000); // zero step
        send_cmd(DATA_MAX, DATA_MIN, 16'hFFFF); // negated angle saturates
        send_cmd(DATA_MIN, DATA_MAX, 16'h0001); // full swing over the shortest step
        send_cmd(DATA_MAX, DATA_MIN, 16'h0001);
        send_cmd('0, '0, 16'h0001);
        send_cmd('1, ONE, 16'hFFFF);

        // extreme gains, zero linear limit
        program_regs(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN,
                     '0, DATA_MAX);
        send_cmd(ONE, -ONE, 16'h0001);
        send_cmd(DATA_MIN, DATA_MIN, 16'hFFFF);
        send_cmd(DATA_MAX, DATA_MAX, 16'h0002);
        send_cmd('1, '0, 16'h0000);
        send_cmd(DATA_MIN, DATA_MAX, 16'h0001);
        send_cmd(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);

        // tight limits
        program_regs(4 * ONE, -ONE, ONE, ONE >> 4, -(2 * ONE), -ONE, 32'd1, 32'h8000);
        send_cmd(ONE, ONE, 16'h0100);
        send_cmd(-ONE, -ONE, 16'h0100);
        send_cmd(32'h0000_0001, 32'hFFFF_FFFF, 16'hAAAA);
        send_cmd(DATA_MAX, DATA_MIN, 16'h0000);
        send_cmd('0, '0, 16'hFFFF);

        // back to the power-up settings
        program_regs('0, '0, '0, '0, '0, '0, 32'(LIM_RESET), 32'(LIM_RESET));
        send_cmd(ONE, ONE, 16'h1000);
        send_cmd(DATA_MIN, DATA_MAX, 16'h0001);
        send_cmd('0, '0, 16'h0000);

        bursty = 1'b1;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % RECONFIG_EVERY == 0 && i < QUIET_FROM)
                program_regs(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                             rand_gain(), rand_gain(), rand_limit(), rand_limit());
            if (i % 60 == 0)
                bursty = ($urandom_range(0, 2) != 0);
            // no idling on either side in the closing stretch
            idle_on <= bursty && (i < QUIET_FROM);
            if (i < QUIET_FROM && bursty && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 13));
            else if (i < QUIET_FROM && $urandom_range(0, 49) == 0)
                wait_drained();
            send_cmd(rand_err(), rand_err(), rand_step());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands over %0d register settings, %0d forming a D term.",
                 cmds_sent, settings, n_deriv);
        $display("Compared %0d velocity pairs, %0d loop outputs clamped, %0d missing.",
                 n_checked, n_clamped, n_pending);
        if (n_fail == 0 && n_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
